/* src/i2cee_pkg.sv */
`default_nettype none
package i2cee_pkg;
  localparam int unsigned AddrWidthDefault = 16;
  localparam logic [8:0] PageBytesReset = 9'd16;
  localparam logic [7:0] RetryLimitReset = 8'd50;
  localparam logic [7:0] RetryGapReset = 8'd20;
  localparam logic [7:0] CtrlWrite = 8'hA0;
  localparam logic [7:0] CtrlRead = 8'hA1;
  localparam logic [7:0] FoldMask = 8'h0E;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_READ = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_WIDE = 2'd0,
    REG_PAGE = 2'd1,
    REG_LIMIT = 2'd2,
    REG_GAP = 2'd3
  } reg_index_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_STA, PH_STB, PH_STC, PH_WSET, PH_WHIGH, PH_WLOW, PH_AREL,
    PH_AHIGH, PH_REQ, PH_WLOAD, PH_RREL, PH_RHIGH, PH_RLOW, PH_MACK, PH_GAP,
    PH_SPA, PH_SPB
  } phase_t;

  typedef enum logic [2:0] {
    SG_CTRL, SG_HI, SG_LO, SG_RDCTRL, SG_DATA
  } stage_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] start_address;
    logic [15:0] length;
    logic [7:0]  wr_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_enable;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       data_request;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } out_item_t;

  typedef struct packed {
    logic       wide_address;
    logic [8:0] page_bytes;
    logic [7:0] retry_limit;
    logic [7:0] retry_gap;
  } cfg_t;
endpackage
`default_nettype wire

/* src/i2cee_if.sv */
`default_nettype none
interface i2cee_in_if;
  logic valid;
  logic ready;
  i2cee_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cee_out_if;
  logic valid;
  logic ready;
  i2cee_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/i2cee_cfg.sv */
`default_nettype none
module i2cee_cfg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  output i2cee_pkg::cfg_t cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wide_address <= 1'b0;
      cfg.page_bytes <= i2cee_pkg::PageBytesReset;
      cfg.retry_limit <= i2cee_pkg::RetryLimitReset;
      cfg.retry_gap <= i2cee_pkg::RetryGapReset;
    end else if (cfg_write) begin
      unique case (i2cee_pkg::reg_index_t'(cfg_index))
        i2cee_pkg::REG_WIDE:  cfg.wide_address <= cfg_data[0];
        i2cee_pkg::REG_PAGE:  cfg.page_bytes <= cfg_data;
        i2cee_pkg::REG_LIMIT: cfg.retry_limit <= cfg_data[7:0];
        i2cee_pkg::REG_GAP:   cfg.retry_gap <= cfg_data[7:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/i2cee_seq.sv */
`default_nettype none
module i2cee_seq #(
  parameter int unsigned ADDR_WIDTH = i2cee_pkg::AddrWidthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire i2cee_pkg::in_item_t item,
  input  wire i2cee_pkg::cfg_t     cfg,
  output i2cee_pkg::out_item_t     res
);
  i2cee_pkg::phase_t phase, phase_next;
  i2cee_pkg::stage_t stage, stage_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [ADDR_WIDTH-1:0] current_address, current_address_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0] attempt_count, attempt_count_next;
  logic [7:0] gap_count, gap_count_next;
  logic is_write, is_write_next, ok_flag, ok_flag_next;

  logic [15:0] addr16;
  logic [8:0] pmask;
  logic [7:0] stage_byte;
  logic [ADDR_WIDTH-1:0] addr_inc;
  logic [15:0] left_dec;
  logic [7:0] attempt_inc, gap_inc;

  assign addr16 = 16'(current_address);
  assign pmask = cfg.page_bytes - 9'd1;
  assign addr_inc = current_address + 1'b1;
  assign left_dec = bytes_left - 16'd1;
  assign attempt_inc = attempt_count + 8'd1;
  assign gap_inc = gap_count + 8'd1;

  always_comb begin
    case (stage_next)
      i2cee_pkg::SG_CTRL:
        stage_byte = cfg.wide_address ? i2cee_pkg::CtrlWrite
          : (((addr16[14:7]) & i2cee_pkg::FoldMask) | i2cee_pkg::CtrlWrite);
      i2cee_pkg::SG_HI:     stage_byte = addr16[15:8];
      i2cee_pkg::SG_LO:     stage_byte = addr16[7:0];
      i2cee_pkg::SG_RDCTRL: stage_byte = i2cee_pkg::CtrlRead;
      default:              stage_byte = shift_byte;
    endcase
  end

  always_comb begin
    i2cee_pkg::phase_t ph;
    logic ack;
    phase_next = phase; stage_next = stage; bit_count_next = bit_count;
    shift_byte_next = shift_byte; current_address_next = current_address;
    bytes_left_next = bytes_left; attempt_count_next = attempt_count;
    gap_count_next = gap_count; is_write_next = is_write; ok_flag_next = ok_flag;
    res = '0;
    res.scl = 1'b1; res.sda_out = 1'b1; res.sda_enable = 1'b1; res.busy_res = 1'b1;
    ack = ~item.sda_in;
    ph = phase;
    if (phase == i2cee_pkg::PH_IDLE && (item.opcode == i2cee_pkg::OP_READ
        || item.opcode == i2cee_pkg::OP_WRITE)) begin
      is_write_next = (item.opcode == i2cee_pkg::OP_WRITE);
      current_address_next = item.start_address[ADDR_WIDTH-1:0];
      bytes_left_next = item.length;
      ok_flag_next = 1'b0;
      attempt_count_next = '0;
      stage_next = i2cee_pkg::SG_CTRL;
      ph = i2cee_pkg::PH_STA;
    end
    unique case (ph)
      i2cee_pkg::PH_STA: begin res.sda_out = 1'b0; phase_next = i2cee_pkg::PH_STB; end
      i2cee_pkg::PH_STB: phase_next = i2cee_pkg::PH_STC;
      i2cee_pkg::PH_STC: begin
        res.sda_out = 1'b0; phase_next = i2cee_pkg::PH_WSET; bit_count_next = '0;
        shift_byte_next = stage_byte;
      end
      i2cee_pkg::PH_WSET, i2cee_pkg::PH_WLOAD: begin
        res.scl = 1'b0;
        if (ph == i2cee_pkg::PH_WLOAD) begin
          shift_byte_next = item.wr_data; bit_count_next = '0;
          res.sda_out = item.wr_data[7];
        end else res.sda_out = shift_byte[7];
        phase_next = i2cee_pkg::PH_WHIGH;
      end
      i2cee_pkg::PH_WHIGH: begin res.sda_out = shift_byte[7]; phase_next = i2cee_pkg::PH_WLOW; end
      i2cee_pkg::PH_WLOW: begin
        res.scl = 1'b0; res.sda_out = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next = bit_count + 4'd1;
        phase_next = (bit_count_next >= 4'd8) ? i2cee_pkg::PH_AREL : i2cee_pkg::PH_WSET;
      end
      i2cee_pkg::PH_AREL: begin
        res.scl = 1'b0; res.sda_out = 1'b0; res.sda_enable = 1'b0;
        phase_next = i2cee_pkg::PH_AHIGH;
      end
      i2cee_pkg::PH_AHIGH: begin
        res.sda_out = 1'b0; res.sda_enable = 1'b0;
        case (stage)
          i2cee_pkg::SG_CTRL, i2cee_pkg::SG_HI, i2cee_pkg::SG_LO: begin
            if (!ack) begin
              gap_count_next = '0;
              if (cfg.retry_gap == 8'd0) begin
                attempt_count_next = attempt_inc;
                if (attempt_inc >= cfg.retry_limit) begin
                  ok_flag_next = 1'b0; phase_next = i2cee_pkg::PH_SPA;
                end else begin
                  stage_next = i2cee_pkg::SG_CTRL; phase_next = i2cee_pkg::PH_STA;
                end
              end else phase_next = i2cee_pkg::PH_GAP;
            end else if (stage == i2cee_pkg::SG_LO) begin
              if (!is_write) begin
                stage_next = i2cee_pkg::SG_RDCTRL; phase_next = i2cee_pkg::PH_STA;
              end else if (bytes_left == 16'd0) begin
                ok_flag_next = 1'b1; phase_next = i2cee_pkg::PH_SPA;
              end else phase_next = i2cee_pkg::PH_REQ;
            end else begin
              stage_next = (stage == i2cee_pkg::SG_CTRL && cfg.wide_address)
                ? i2cee_pkg::SG_HI : i2cee_pkg::SG_LO;
              shift_byte_next = stage_byte; bit_count_next = '0;
              phase_next = i2cee_pkg::PH_WSET;
            end
          end
          i2cee_pkg::SG_RDCTRL: begin
            if (!ack) begin ok_flag_next = 1'b0; phase_next = i2cee_pkg::PH_SPA; end
            else if (bytes_left == 16'd0) begin
              ok_flag_next = 1'b1; phase_next = i2cee_pkg::PH_SPA;
            end else phase_next = i2cee_pkg::PH_RREL;
          end
          default: begin
            if (!ack) begin ok_flag_next = 1'b0; phase_next = i2cee_pkg::PH_SPA; end
            else begin
              current_address_next = addr_inc;
              bytes_left_next = left_dec;
              if (left_dec == 16'd0) begin
                ok_flag_next = 1'b1; phase_next = i2cee_pkg::PH_SPA;
              end else if ((16'(addr_inc) & 16'(pmask)) == 16'd0) begin
                attempt_count_next = '0; stage_next = i2cee_pkg::SG_CTRL;
                phase_next = i2cee_pkg::PH_STA;
              end else phase_next = i2cee_pkg::PH_REQ;
            end
          end
        endcase
      end
      i2cee_pkg::PH_REQ: begin
        res.scl = 1'b0; res.sda_out = 1'b0; res.data_request = 1'b1;
        stage_next = i2cee_pkg::SG_DATA; phase_next = i2cee_pkg::PH_WLOAD;
      end
      i2cee_pkg::PH_RREL: begin
        res.scl = 1'b0; res.sda_out = 1'b0; res.sda_enable = 1'b0;
        shift_byte_next = '0; bit_count_next = '0; phase_next = i2cee_pkg::PH_RHIGH;
      end
      i2cee_pkg::PH_RHIGH: begin
        res.sda_out = 1'b0; res.sda_enable = 1'b0;
        shift_byte_next = {shift_byte[6:0], item.sda_in}; phase_next = i2cee_pkg::PH_RLOW;
      end
      i2cee_pkg::PH_RLOW: begin
        res.scl = 1'b0; res.sda_out = 1'b0; res.sda_enable = 1'b0;
        bit_count_next = bit_count + 4'd1;
        if (bit_count_next < 4'd8) phase_next = i2cee_pkg::PH_RHIGH;
        else begin
          res.rd_data = shift_byte; res.rd_valid = 1'b1;
          current_address_next = addr_inc; bytes_left_next = left_dec;
          if (left_dec == 16'd0) begin
            ok_flag_next = 1'b1; phase_next = i2cee_pkg::PH_SPA;
          end else phase_next = i2cee_pkg::PH_MACK;
        end
      end
      i2cee_pkg::PH_MACK: begin res.sda_out = 1'b0; phase_next = i2cee_pkg::PH_RREL; end
      i2cee_pkg::PH_GAP: begin
        res.scl = 1'b0; res.sda_out = 1'b0;
        gap_count_next = gap_inc;
        if (gap_inc >= cfg.retry_gap) begin
          attempt_count_next = attempt_inc;
          if (attempt_inc >= cfg.retry_limit) begin
            ok_flag_next = 1'b0; phase_next = i2cee_pkg::PH_SPA;
          end else begin
            stage_next = i2cee_pkg::SG_CTRL; phase_next = i2cee_pkg::PH_STA;
          end
        end
      end
      i2cee_pkg::PH_SPA: begin res.sda_out = 1'b0; phase_next = i2cee_pkg::PH_SPB; end
      i2cee_pkg::PH_SPB: begin
        res.done_res = 1'b1; res.success = ok_flag; phase_next = i2cee_pkg::PH_IDLE;
      end
      default: begin phase_next = i2cee_pkg::PH_IDLE; res.busy_res = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cee_pkg::PH_IDLE; stage <= i2cee_pkg::SG_CTRL;
      bit_count <= '0; shift_byte <= '0; current_address <= '0; bytes_left <= '0;
      attempt_count <= '0; gap_count <= '0; is_write <= 1'b0; ok_flag <= 1'b0;
    end else if (step) begin
      phase <= phase_next; stage <= stage_next; bit_count <= bit_count_next;
      shift_byte <= shift_byte_next; current_address <= current_address_next;
      bytes_left <= bytes_left_next; attempt_count <= attempt_count_next;
      gap_count <= gap_count_next; is_write <= is_write_next; ok_flag <= ok_flag_next;
    end
  end
endmodule
`default_nettype wire

/* src/i2c_eeprom_access_master.sv */
`default_nettype none
// Channel   Role     Payload
// in_ch     sink     opcode, start_address, length, wr_data, sda_in (one bus tick)
// out_ch    source   scl, sda_out, sda_enable, rd_data, rd_valid, data_request,
//                    busy_res, done_res, success
// One transaction in gives one transaction out, one clock each, back to back while the output is not stalled.
// The input is held in a register; the sequencer is combinational from that register
// into the result register, which is loaded on the same step that advances its state.
// in ready is high whenever the result register is empty or being taken, so a stall
// on the output holds exactly one finished result and pauses input once in_reg is full.
// Reset (rst, synchronous) empties both registers and idles the sequencer.
module i2c_eeprom_access_master #(
  parameter int unsigned ADDR_WIDTH = i2cee_pkg::AddrWidthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  i2cee_in_if.sink        in_ch,
  i2cee_out_if.source     out_ch
);
  i2cee_pkg::cfg_t cfg;
  i2cee_pkg::in_item_t in_reg;
  i2cee_pkg::out_item_t res;
  logic in_full, out_full, step;

  i2cee_cfg u_cfg (.clk, .rst, .cfg_write, .cfg_index, .cfg_data, .cfg);

  // step: input register full and result register free to take it
  assign step = in_full && (!out_full || out_ch.ready);
  assign in_ch.ready = !in_full || step;

  i2cee_seq #(.ADDR_WIDTH(ADDR_WIDTH)) u_seq (
    .clk, .rst, .step, .item(in_reg), .cfg, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (in_ch.ready) in_full <= in_ch.valid;
      if (step) out_full <= 1'b1;
      else if (out_ch.ready) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_reg <= in_ch.data;
    if (step) out_ch.data <= res;
  end

  assign out_ch.valid = out_full;

`ifndef SYNTHESIS
  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> out_full) else $error("result register not filled after step");
  a_stall_holds_in: assert property (@(posedge clk) disable iff (rst)
    (in_full && out_full && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (step && res.done_res) |-> res.busy_res)
    else $error("done without busy");
`endif
endmodule
`default_nettype wire

/* verif/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cee_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerSetting = 100;
  localparam int unsigned DrainCycles = 6;

  // Idle bus as seen after reset: lines high, driven, nothing in progress.
  localparam out_item_t BusIdle = '{scl: 1'b1, sda_out: 1'b1, sda_enable: 1'b1,
                                    rd_data: 8'h00, rd_valid: 1'b0, data_request: 1'b0,
                                    busy_res: 1'b0, done_res: 1'b0, success: 1'b0};
  // First tick of a START: SDA pulled low under a high SCL.
  localparam out_item_t BusStartA = '{scl: 1'b1, sda_out: 1'b0, sda_enable: 1'b1,
                                      rd_data: 8'h00, rd_valid: 1'b0, data_request: 1'b0,
                                      busy_res: 1'b1, done_res: 1'b0, success: 1'b0};

  // Short retry settings for the directed part, so a refused address gives up quickly.
  localparam cfg_t DirectedSettings = '{1'b0, 9'd16, 8'd2, 8'd3};

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  i2cee_in_if in_ch ();
  i2cee_out_if out_ch ();

  i2c_eeprom_access_master u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Bus sequencer mirror: configuration and state of the EEPROM master.
  logic        cfg_wide;
  logic [8:0]  cfg_page;
  logic [7:0]  cfg_limit;
  logic [7:0]  cfg_gap;

  phase_t      bus_phase;
  stage_t      byte_stage;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [15:0] cur_addr;
  logic [15:0] bytes_left;
  logic [7:0]  tries;
  logic [7:0]  gap_cnt;
  logic        writing;
  logic        ok_flag;

  out_item_t   bus_expect_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;
  logic [15:0] ready_pattern;
  int unsigned ready_pos;

  // Side channel from the driver: a directed row may carry a typed-in result.
  logic        row_typed;
  out_item_t   row_exp;

  typedef struct {
    opcode_t     op;
    logic [15:0] addr;
    logic [15:0] len;
    logic [7:0]  wr;
    logic        sda;
    int          settle_ack;
    bit          settle;
    bit          typed;
    out_item_t   exp;
  } dir_row_t;

  // Directed rows; rows that settle keep ticking until the transfer is over,
  // acknowledging address and data with the given percentage.
  dir_row_t dir_rows[10] = '{
    '{OP_TICK,  16'h0000, 16'h0000, 8'h00, 1'b0, -1,  1'b0, 1'b1, BusIdle},
    '{OP_NONE,  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, -1,  1'b0, 1'b1, BusIdle},
    // never acknowledged: retries until the limit, then fails with STOP
    '{OP_READ,  16'hFFFF, 16'hFFFF, 8'h00, 1'b1, 0,   1'b1, 1'b1, BusStartA},
    // zero length write, high bits folded into the control byte
    '{OP_WRITE, 16'h07FF, 16'h0000, 8'hFF, 1'b0, 100, 1'b1, 1'b0, BusIdle},
    '{OP_READ,  16'h0500, 16'h0000, 8'h00, 1'b0, 100, 1'b1, 1'b0, BusIdle},
    // read across the top of the address space
    '{OP_READ,  16'hFFFE, 16'h0003, 8'h00, 1'b0, 100, 1'b1, 1'b0, BusIdle},
    // write crossing a page boundary
    '{OP_WRITE, 16'h000E, 16'h0004, 8'h5A, 1'b0, 100, 1'b1, 1'b0, BusIdle},
    // page boundary straight after the last byte
    '{OP_WRITE, 16'h001E, 16'h0002, 8'hA5, 1'b0, 100, 1'b1, 1'b0, BusIdle},
    '{OP_WRITE, 16'h1234, 16'h0003, 8'h00, 1'b0, 60,  1'b1, 1'b0, BusIdle},
    '{OP_READ,  16'h00FF, 16'h0002, 8'h00, 1'b0, 60,  1'b1, 1'b0, BusIdle}
  };

  cfg_t settings[5] = '{
    '{1'b1, 9'd256, 8'd255, 8'd255},
    '{1'b0, 9'd1,   8'd1,   8'd0},
    '{1'b1, 9'd0,   8'd0,   8'd1},
    '{1'b0, 9'd3,   8'd3,   8'd5},
    '{1'b1, 9'd16,  8'd50,  8'd20}
  };

  function automatic logic [7:0] stage_byte_value();
    case (byte_stage)
      SG_CTRL:   return cfg_wide ? CtrlWrite : (8'(cur_addr >> 7) & FoldMask) | CtrlWrite;
      SG_HI:     return cur_addr[15:8];
      SG_LO:     return cur_addr[7:0];
      SG_RDCTRL: return CtrlRead;
      default:   return shreg;
    endcase
  endfunction

  function automatic void load_next_byte();
    shreg = stage_byte_value();
    bit_cnt = '0;
    bus_phase = PH_WSET;
  endfunction

  function automatic void start_addressing();
    tries = '0;
    byte_stage = SG_CTRL;
    bus_phase = PH_STA;
  endfunction

  function automatic void conclude(input logic good);
    ok_flag = good;
    bus_phase = PH_SPA;
  endfunction

  function automatic void next_attempt();
    tries = tries + 8'd1;
    if (tries >= cfg_limit) begin
      conclude(1'b0);
    end else begin
      byte_stage = SG_CTRL;
      bus_phase = PH_STA;
    end
  endfunction

  function automatic void address_refused();
    gap_cnt = '0;
    if (cfg_gap == 8'd0) next_attempt();
    else bus_phase = PH_GAP;
  endfunction

  function automatic void acknowledge_outcome(input logic ack);
    logic [8:0] pmask;
    pmask = cfg_page - 9'd1;
    case (byte_stage)
      SG_CTRL, SG_HI: begin
        if (!ack) begin
          address_refused();
        end else begin
          byte_stage = (byte_stage == SG_CTRL && cfg_wide) ? SG_HI : SG_LO;
          load_next_byte();
        end
      end
      SG_LO: begin
        if (!ack) address_refused();
        else if (!writing) begin
          byte_stage = SG_RDCTRL;
          bus_phase = PH_STA;
        end else if (bytes_left == 16'd0) conclude(1'b1);
        else bus_phase = PH_REQ;
      end
      SG_RDCTRL: begin
        if (!ack) conclude(1'b0);
        else if (bytes_left == 16'd0) conclude(1'b1);
        else bus_phase = PH_RREL;
      end
      default: begin
        if (!ack) begin
          conclude(1'b0);
        end else begin
          cur_addr = cur_addr + 16'd1;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) conclude(1'b1);
          else if ((cur_addr & {7'd0, pmask}) == 16'd0) start_addressing();
          else bus_phase = PH_REQ;
        end
      end
    endcase
  endfunction

  // Advance the mirror by one bus tick and return the pin/status levels.
  function automatic out_item_t bus_tick(input in_item_t it);
    out_item_t o;
    o = '{scl: 1'b1, sda_out: 1'b1, sda_enable: 1'b1, rd_data: 8'h00, rd_valid: 1'b0,
          data_request: 1'b0, busy_res: 1'b1, done_res: 1'b0, success: 1'b0};
    if (bus_phase == PH_IDLE && (it.opcode == OP_READ || it.opcode == OP_WRITE)) begin
      writing = (it.opcode == OP_WRITE);
      cur_addr = it.start_address;
      bytes_left = it.length;
      ok_flag = 1'b0;
      start_addressing();
    end
    case (bus_phase)
      PH_STA: begin
        o.sda_out = 1'b0;
        bus_phase = PH_STB;
      end
      PH_STB: bus_phase = PH_STC;
      PH_STC: begin
        o.sda_out = 1'b0;
        load_next_byte();
      end
      PH_WLOAD, PH_WSET: begin
        if (bus_phase == PH_WLOAD) begin
          shreg = it.wr_data;
          bit_cnt = '0;
        end
        o.scl = 1'b0;
        o.sda_out = shreg[7];
        bus_phase = PH_WHIGH;
      end
      PH_WHIGH: begin
        o.sda_out = shreg[7];
        bus_phase = PH_WLOW;
      end
      PH_WLOW: begin
        o.scl = 1'b0;
        o.sda_out = shreg[7];
        shreg = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        bus_phase = (bit_cnt >= 4'd8) ? PH_AREL : PH_WSET;
      end
      PH_AREL: begin
        o.scl = 1'b0;
        o.sda_out = 1'b0;
        o.sda_enable = 1'b0;
        bus_phase = PH_AHIGH;
      end
      PH_AHIGH: begin
        o.sda_out = 1'b0;
        o.sda_enable = 1'b0;
        acknowledge_outcome(it.sda_in == 1'b0);
      end
      PH_REQ: begin
        o.scl = 1'b0;
        o.sda_out = 1'b0;
        o.data_request = 1'b1;
        byte_stage = SG_DATA;
        bus_phase = PH_WLOAD;
      end
      PH_RREL: begin
        o.scl = 1'b0;
        o.sda_out = 1'b0;
        o.sda_enable = 1'b0;
        shreg = '0;
        bit_cnt = '0;
        bus_phase = PH_RHIGH;
      end
      PH_RHIGH: begin
        o.sda_out = 1'b0;
        o.sda_enable = 1'b0;
        shreg = {shreg[6:0], it.sda_in};
        bus_phase = PH_RLOW;
      end
      PH_RLOW: begin
        o.scl = 1'b0;
        o.sda_out = 1'b0;
        o.sda_enable = 1'b0;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < 4'd8) begin
          bus_phase = PH_RHIGH;
        end else begin
          o.rd_data = shreg;
          o.rd_valid = 1'b1;
          cur_addr = cur_addr + 16'd1;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) conclude(1'b1);
          else bus_phase = PH_MACK;
        end
      end
      PH_MACK: begin
        o.sda_out = 1'b0;
        bus_phase = PH_RREL;
      end
      PH_GAP: begin
        o.scl = 1'b0;
        o.sda_out = 1'b0;
        gap_cnt = gap_cnt + 8'd1;
        if (gap_cnt >= cfg_gap) next_attempt();
      end
      PH_SPA: begin
        o.sda_out = 1'b0;
        bus_phase = PH_SPB;
      end
      PH_SPB: begin
        o.done_res = 1'b1;
        o.success = ok_flag;
        bus_phase = PH_IDLE;
      end
      default: begin
        bus_phase = PH_IDLE;
        o.busy_res = 1'b0;
      end
    endcase
    return o;
  endfunction

  task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  // Play the EEPROM: acknowledge addressing/data with the given odds,
  // otherwise put a random level on SDA (read data bits among them).
  function automatic logic eeprom_sda(input int ack_pct);
    if (bus_phase == PH_AHIGH) return ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic in_item_t random_tick();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom(), $urandom()}));
    it.opcode = OP_TICK;
    return it;
  endfunction

  function automatic logic [15:0] random_address();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return (16'($urandom()) & 16'hFFF0) - 16'($urandom_range(0, 2));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned roll;
    it = random_tick();
    roll = $urandom_range(0, 99);
    // starts while busy are thrown in too: they must be ignored
    if (roll < ((bus_phase == PH_IDLE) ? 50 : 5)) begin
      it.opcode = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      it.start_address = random_address();
      it.length = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4))
                                              : 16'($urandom_range(5, 40));
    end else if (roll > 95) begin
      it.opcode = OP_NONE;
    end
    return it;
  endfunction

  // Drive one tick transaction; bursts with random gaps in between.
  task automatic send_tick(input in_item_t it, input int ack_pct, input bit typed,
                           input out_item_t typed_val);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    if (ack_pct >= 0) it.sda_in = eeprom_sda(ack_pct);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    row_typed <= typed;
    row_exp <= typed_val;
    do @(posedge clk); while (!in_ch.ready);
    // let the mirror take this edge before the caller looks at its state
    #0.1;
  endtask

  task automatic run_to_idle(input int ack_pct);
    while (bus_phase != PH_IDLE) send_tick(random_tick(), ack_pct, 1'b0, BusIdle);
  endtask

  task automatic wait_results();
    while (bus_expect_q.size() != 0) @(posedge clk);
  endtask

  // Registers are written only with the block idle and nothing outstanding.
  task automatic write_settings(input cfg_t s);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_results();
    repeat (DrainCycles) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_WIDE;
    cfg_data <= {8'd0, s.wide_address};
    @(negedge clk);
    cfg_index <= REG_PAGE;
    cfg_data <= s.page_bytes;
    @(negedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data <= {1'b0, s.retry_limit};
    @(negedge clk);
    cfg_index <= REG_GAP;
    cfg_data <= {1'b0, s.retry_gap};
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_wide = s.wide_address;
    cfg_page = s.page_bytes;
    cfg_limit = s.retry_limit;
    cfg_gap = s.retry_gap;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls follow the bits of the 16-bit ready_pattern in turn, changed per setting.
  always @(negedge clk) begin
    out_ch.ready <= ready_pattern[ready_pos];
    ready_pos <= (ready_pos + 1) % 16;
  end

  // Compare each result with the oldest expectation, then record the new one.
  always @(posedge clk) begin
    if (!rst) begin
      out_item_t exp_item;
      out_item_t got;
      out_item_t pred;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (bus_expect_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %0h", $time, got);
          mismatches++;
        end else begin
          exp_item = bus_expect_q.pop_front();
          check_field("scl", exp_item.scl, got.scl);
          check_field("sda_out", exp_item.sda_out, got.sda_out);
          check_field("sda_enable", exp_item.sda_enable, got.sda_enable);
          check_field("rd_data", exp_item.rd_data, got.rd_data);
          check_field("rd_valid", exp_item.rd_valid, got.rd_valid);
          check_field("data_request", exp_item.data_request, got.data_request);
          check_field("busy_res", exp_item.busy_res, got.busy_res);
          check_field("done_res", exp_item.done_res, got.done_res);
          check_field("success", exp_item.success, got.success);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = bus_tick(in_ch.data);
        bus_expect_q.push_back(row_typed ? row_exp : pred);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WIDE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    row_typed = 1'b0;
    row_exp = BusIdle;
    ready_pattern = 16'hFFFF;
    ready_pos = 0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    cfg_wide = 1'b0;
    cfg_page = PageBytesReset;
    cfg_limit = RetryLimitReset;
    cfg_gap = RetryGapReset;
    bus_phase = PH_IDLE;
    byte_stage = SG_CTRL;
    bit_cnt = '0;
    shreg = '0;
    cur_addr = '0;
    bytes_left = '0;
    tries = '0;
    gap_cnt = '0;
    writing = 1'b0;
    ok_flag = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    ready_pattern = 16'hB5FF;

    // Directed part; shorten the retries first so the refused address ends soon.
    write_settings(DirectedSettings);
    foreach (dir_rows[i]) begin
      it = '0;
      it.opcode = dir_rows[i].op;
      it.start_address = dir_rows[i].addr;
      it.length = dir_rows[i].len;
      it.wr_data = dir_rows[i].wr;
      it.sda_in = dir_rows[i].sda;
      send_tick(it, -1, dir_rows[i].typed, dir_rows[i].exp);
      if (dir_rows[i].settle) run_to_idle(dir_rows[i].settle_ack);
    end

    // Random part over several settings; a stretch of noisy acknowledges
    // in each hundred items to exercise retries and failures.
    foreach (settings[s]) begin
      write_settings(settings[s]);
      ready_pattern = (s % 2 == 1) ? 16'hFFFF : 16'($urandom()) | 16'h0101;
      for (int unsigned n = 0; n < ItemsPerSetting; n++) begin
        if (s == 1 && n == ItemsPerSetting / 2) begin
          // hold the sender until every outstanding result is back
          @(negedge clk);
          in_ch.valid <= 1'b0;
          wait_results();
        end
        send_tick(random_item(), (n % 100 < 15) ? 50 : 93, 1'b0, BusIdle);
      end
      run_to_idle(93);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

`default_nettype wire
